// ----- rtl/psm_pkg.sv -----
// Shared constants, types and the quarter-wave sine table of the voice mixer.
package psm_pkg;

	// Pool and format sizes
	localparam int NUM_VOICES = 16;
	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int SAMPLE_BITS = 16;

	localparam int VOICE_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int COUNT_W = $clog2(NUM_VOICES + 1);
	localparam int SINE_W = $clog2(SINE_TABLE_DEPTH);
	localparam int QUARTER = SINE_TABLE_DEPTH / 4;
	localparam int QIDX_W = $clog2(QUARTER + 1);
	localparam int ACC_W = VOICE_W + 18;
	localparam int FULL_SCALE = (2 ** (SAMPLE_BITS - 1)) - 1;

	// Shared multiplier operand widths
	localparam int MUL_A_W = 26;
	localparam int MUL_B_W = 18;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Divider widths: the quotient never exceeds one in Q16
	localparam int DIV_NUM_W = 37;
	localparam int DIV_DEN_W = 20;
	localparam int DIV_Q_W = 17;
	localparam int DIV_CNT_W = 5;

	localparam int MIN_TAIL = 44;
	localparam logic [16:0] Q16_ONE = 17'd65536;

	// Operation codes
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_NOTE = 2'd1;
	localparam logic [1:0] OP_PANIC = 2'd2;

	// Result status codes
	localparam logic [1:0] STAT_SAMPLE = 2'd0;
	localparam logic [1:0] STAT_ACCEPTED = 2'd1;
	localparam logic [1:0] STAT_DROPPED = 2'd2;
	localparam logic [1:0] STAT_SILENCED = 2'd3;

	// Oscillator shapes
	localparam logic [1:0] WAVE_SINE = 2'd0;
	localparam logic [1:0] WAVE_SQUARE = 2'd1;
	localparam logic [1:0] WAVE_TRIANGLE = 2'd2;
	localparam logic [1:0] WAVE_SAW = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] CFG_WAVE = 3'd0;
	localparam logic [2:0] CFG_ATTACK = 3'd1;
	localparam logic [2:0] CFG_DECAY = 3'd2;
	localparam logic [2:0] CFG_SUSTAIN = 3'd3;
	localparam logic [2:0] CFG_RELEASE = 3'd4;
	localparam logic [2:0] CFG_LOWPASS = 3'd5;
	localparam logic [2:0] CFG_SYNTH_VOL = 3'd6;
	localparam logic [2:0] CFG_MASTER_VOL = 3'd7;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_NOTE,
		ST_NOTE_WR,
		ST_VSEL,
		ST_OSC,
		ST_ENV_DIV,
		ST_DIV_WAIT,
		ST_AMP1,
		ST_AMP2,
		ST_FILT,
		ST_FILT_MUL,
		ST_FILT_WR,
		ST_ACC,
		ST_MIX,
		ST_MIX2,
		ST_MIX3,
		ST_MIX4,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		ENV_ATTACK,
		ENV_DECAY,
		ENV_SUSTAIN,
		ENV_RELEASE,
		ENV_ZERO
	} env_kind_t;

	typedef struct packed {
		logic start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef logic [16:0] sine_rom_t [0:QUARTER];

	// First-quadrant sine magnitudes in Q16, from a Q30 Taylor series.
	function automatic sine_rom_t build_sine();
		sine_rom_t rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] mag;
		for (int j = 0; j <= QUARTER; j++) begin
			x = (64'(4 * j) * 64'd1686629713) / 64'(SINE_TABLE_DEPTH);
			x2 = (x * x) >> 30;
			t = 64'd1073741824 - x2 / 64'd72;
			t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
			t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
			t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
			s = (x * t) >> 30;
			mag = (s + 64'd8192) >> 14;
			if (mag > 64'd65536) begin
				mag = 64'd65536;
			end
			rom[j] = 17'(mag);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine();

endpackage

// ----- rtl/psm_cmd_if.sv -----
// Command channel: one tick, note-on or panic request per handshake.
interface psm_cmd_if;
	logic valid;
	logic ready;
	logic [1:0] operation;
	logic [31:0] phase_step;
	logic [23:0] note_length;
	logic [15:0] note_velocity;

	modport source(output valid, operation, phase_step, note_length, note_velocity,
		input ready);
	modport sink(input valid, operation, phase_step, note_length, note_velocity,
		output ready);
endinterface

// ----- rtl/psm_mix_if.sv -----
// Result channel: mixed sample, status and active voice count per request.
interface psm_mix_if;
	logic valid;
	logic ready;
	logic signed [15:0] audio_sample;
	logic [1:0] status;
	logic [4:0] active_voices;

	modport source(output valid, audio_sample, status, active_voices, input ready);
	modport sink(input valid, audio_sample, status, active_voices, output ready);
endinterface

// ----- rtl/psm_mul.sv -----
// Shared signed multiplier with a registered product.
module psm_mul (
	input logic clk,
	input logic signed [psm_pkg::MUL_A_W-1:0] a,
	input logic signed [psm_pkg::MUL_B_W-1:0] b,
	output logic signed [psm_pkg::MUL_P_W-1:0] p
);
	import psm_pkg::*;

	logic signed [MUL_P_W-1:0] p_q;

	// One product per cycle, available the cycle after the operands.
	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

	assign p = p_q;
endmodule

// ----- rtl/psm_div.sv -----
// Restoring divider, one quotient bit per cycle, for envelope ramps.
module psm_div (
	input logic clk,
	input logic arst_n,
	input psm_pkg::div_ctrl_t ctrl,
	output psm_pkg::div_stat_t stat,
	output logic [psm_pkg::DIV_Q_W-1:0] quotient
);
	import psm_pkg::*;

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_Q_W-1:0] low_q;
	logic [DIV_Q_W-1:0] quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DIV_DEN_W:0] trial;
	logic fits;

	// Bring down the next numerator bit and try a subtraction.
	assign trial = {rem_q, low_q[DIV_Q_W-1]};
	assign fits = trial >= {1'b0, den_q};

	// Control: sequence length and done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(DIV_Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the upper numerator bits are known to lie below the divisor.
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q <= ctrl.num[DIV_NUM_W-1:DIV_Q_W];
			low_q <= ctrl.num[DIV_Q_W-1:0];
			den_q <= ctrl.den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_DEN_W'(trial - {1'b0, den_q}) : DIV_DEN_W'(trial);
			low_q <= {low_q[DIV_Q_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_Q_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |-> !busy_q)
		else $error("divider started while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("divider done without a finished division");
endmodule

// ----- rtl/polyphonic_adsr_synth_voice_mixer.sv -----
// Voice pool with ADSR envelopes, oscillators, low-pass and master mix.
//
// Requests arrive on cmd (valid/ready): a tick makes one mixed sample, a
// note-on claims the lowest free voice, a panic frees every voice. Each
// request gives exactly one result on mix (valid/ready) with the sample,
// a status code and the number of voices still active. The user must
// write configuration through cfg_write/cfg_index/cfg_data only while
// no request is open; the block does not enforce this. One shared
// multiplier and one bit-serial divider do all the arithmetic under a
// sequencer, so one request is in flight at a time: cmd.ready is high
// only while the sequencer is idle.
// The result sits in an output register; a new request is taken while it
// waits, but the next result holds in the sequencer until mix.ready.
// Reset frees all voices and loads the default configuration.
module polyphonic_adsr_synth_voice_mixer (
	input logic clk,
	input logic arst_n,
	psm_cmd_if.sink cmd,
	psm_mix_if.source mix,
	input logic cfg_write,
	input logic [2:0] cfg_index,
	input logic [19:0] cfg_data
);
	import psm_pkg::*;

	// Configuration registers
	logic [1:0] wave_q;
	logic [19:0] attack_q;
	logic [19:0] decay_q;
	logic [15:0] sustain_q;
	logic [19:0] release_q;
	logic [16:0] alpha_q;
	logic [15:0] synth_vol_q;
	logic [15:0] master_q;

	// Latched request
	logic [31:0] step_in_q;
	logic [23:0] len_q;
	logic [15:0] vel_q;

	// Voice stores
	logic [NUM_VOICES-1:0] active_q;
	logic [31:0] phase_q [NUM_VOICES];
	logic [31:0] step_q [NUM_VOICES];
	logic [24:0] elapsed_q [NUM_VOICES];
	logic [23:0] hold_q [NUM_VOICES];
	logic [15:0] gain_q [NUM_VOICES];
	logic signed [17:0] filter_q [NUM_VOICES];

	// Sequencer and working registers
	state_t state_q, state_d;
	logic [VOICE_W-1:0] v_q;
	logic [COUNT_W-1:0] cnt_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [16:0] sine_q;
	logic [1:0] quad_q;
	env_kind_t env_kind_q;
	logic [19:0] env_x_q;
	logic signed [17:0] osc_q;
	logic [16:0] env_q;
	logic signed [17:0] dry_q;
	logic signed [17:0] wet_q;
	logic signed [17:0] m_q;
	logic [15:0] res_sample_q;
	logic [1:0] res_status_q;

	// Output register
	logic out_valid_q;
	logic [15:0] out_sample_q;
	logic [1:0] out_status_q;
	logic [4:0] out_count_q;

	// Shared units
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	div_ctrl_t div_ctrl;
	div_stat_t div_stat;
	logic [DIV_Q_W-1:0] div_q;

	// Combinational helpers
	logic accept;
	logic found;
	logic [VOICE_W-1:0] free_idx;
	logic [31:0] cur_phase;
	logic [24:0] cur_elapsed;
	logic [23:0] cur_hold;
	logic signed [17:0] cur_filter;
	logic [19:0] tail;
	logic [20:0] a_plus_d;
	logic [24:0] h_plus_tail;
	logic [24:0] e_rel;
	logic [24:0] e_next;
	logic expire;
	env_kind_t kind_d;
	logic [19:0] x_d;
	logic [SINE_W-1:0] sine_k;
	logic [SINE_W-3:0] sine_r;
	logic [QIDX_W-1:0] sine_idx;
	logic [16:0] phase_u;
	logic [15:0] tri_d;
	logic signed [18:0] tri_v;
	logic signed [18:0] saw_v;
	logic signed [17:0] sine_v;
	logic signed [17:0] osc_d;
	logic [16:0] osc_mag;
	logic [16:0] amp_mag;
	logic signed [17:0] dry_d;
	logic signed [27:0] mix_t;
	logic last_voice;
	logic note_wr;
	logic advance;
	logic out_load;

	function automatic logic signed [27:0] trunc_q16(input logic signed [MUL_P_W-1:0] p);
		logic signed [MUL_P_W-1:0] adj;
		adj = p + (p[MUL_P_W-1] ? MUL_P_W'(65535) : MUL_P_W'(0));
		return 28'(adj >>> 16);
	endfunction

	psm_mul u_mul (
		.clk(clk),
		.a(mul_a),
		.b(mul_b),
		.p(mul_p)
	);

	psm_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(div_ctrl),
		.stat(div_stat),
		.quotient(div_q)
	);

	assign accept = cmd.valid && cmd.ready;
	assign last_voice = v_q == VOICE_W'(NUM_VOICES - 1);

	// Lowest free voice for a note-on.
	always_comb begin
		found = 1'b0;
		free_idx = '0;
		for (int i = NUM_VOICES - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				found = 1'b1;
				free_idx = VOICE_W'(i);
			end
		end
	end

	// Current voice fields and envelope segment.
	assign cur_phase = phase_q[v_q];
	assign cur_elapsed = elapsed_q[v_q];
	assign cur_hold = hold_q[v_q];
	assign cur_filter = filter_q[v_q];
	assign tail = (release_q > 20'(MIN_TAIL)) ? release_q : 20'(MIN_TAIL);
	assign a_plus_d = {1'b0, attack_q} + {1'b0, decay_q};
	assign h_plus_tail = {1'b0, cur_hold} + 25'(tail);
	assign e_rel = cur_elapsed - 25'(cur_hold);
	assign e_next = cur_elapsed + 25'd1;
	assign expire = e_next >= h_plus_tail;

	always_comb begin
		kind_d = ENV_ZERO;
		x_d = '0;
		if (attack_q != '0 && cur_elapsed < 25'(attack_q)) begin
			kind_d = ENV_ATTACK;
		end else if (decay_q != '0 && cur_elapsed < 25'(a_plus_d)) begin
			kind_d = ENV_DECAY;
			x_d = 20'(cur_elapsed - 25'(attack_q));
		end else if (cur_elapsed < 25'(cur_hold)) begin
			kind_d = ENV_SUSTAIN;
		end else if (release_q != '0 && cur_elapsed < h_plus_tail) begin
			if (e_rel >= 25'(release_q)) begin
				kind_d = ENV_ZERO;
			end else begin
				kind_d = ENV_RELEASE;
				x_d = release_q - 20'(e_rel);
			end
		end
	end

	// Sine table address folded into the first quadrant.
	assign sine_k = cur_phase[31 -: SINE_W];
	assign sine_r = sine_k[SINE_W-3:0];
	assign sine_idx = sine_k[SINE_W-2] ? QIDX_W'(QUARTER) - QIDX_W'(sine_r)
		: QIDX_W'(sine_r);

	// Oscillator shapes.
	assign phase_u = {1'b0, cur_phase[31:16]};
	assign tri_d = (phase_u >= 17'd32768) ? 16'(phase_u - 17'd32768)
		: 16'(17'd32768 - phase_u);
	assign tri_v = 19'sd65536 - $signed({1'b0, tri_d, 2'b00});
	assign saw_v = $signed({1'b0, phase_u, 1'b0}) - 19'sd65536;
	assign sine_v = quad_q[1] ? -$signed({1'b0, sine_q}) : $signed({1'b0, sine_q});

	always_comb begin
		case (wave_q)
			WAVE_SQUARE: osc_d = cur_phase[31] ? -18'sd65536 : 18'sd65536;
			WAVE_TRIANGLE: osc_d = 18'(tri_v);
			WAVE_SAW: osc_d = 18'(saw_v);
			default: osc_d = sine_v;
		endcase
	end

	assign osc_mag = osc_q[17] ? 17'(-osc_q) : 17'(osc_q);
	assign amp_mag = mul_p[32:16];
	assign dry_d = osc_q[17] ? -$signed({1'b0, amp_mag}) : $signed({1'b0, amp_mag});
	assign mix_t = trunc_q16(mul_p);

	// Sequencer next state and shared unit operands.
	always_comb begin
		state_d = state_q;
		mul_a = '0;
		mul_b = '0;
		div_ctrl.start = 1'b0;
		div_ctrl.num = '0;
		div_ctrl.den = '0;
		note_wr = 1'b0;
		advance = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd.operation == OP_NOTE) begin
						state_d = ST_NOTE;
					end else if (cmd.operation == OP_PANIC) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_VSEL;
					end
				end
			end
			ST_NOTE: begin
				mul_a = MUL_A_W'(vel_q);
				mul_b = MUL_B_W'(synth_vol_q);
				state_d = ST_NOTE_WR;
			end
			ST_NOTE_WR: begin
				note_wr = found;
				state_d = ST_DONE;
			end
			ST_VSEL: begin
				if (active_q[v_q]) begin
					state_d = ST_OSC;
				end else if (last_voice) begin
					state_d = ST_MIX;
				end
			end
			ST_OSC: begin
				mul_a = MUL_A_W'(env_x_q);
				mul_b = (env_kind_q == ENV_DECAY) ? MUL_B_W'(Q16_ONE - {1'b0, sustain_q})
					: MUL_B_W'(sustain_q);
				state_d = ST_ENV_DIV;
			end
			ST_ENV_DIV: begin
				div_ctrl.num = (env_kind_q == ENV_ATTACK)
					? DIV_NUM_W'({cur_elapsed[19:0], 16'd0})
					: mul_p[DIV_NUM_W-1:0];
				div_ctrl.den = (env_kind_q == ENV_ATTACK) ? attack_q
					: (env_kind_q == ENV_DECAY) ? decay_q : release_q;
				if (env_kind_q == ENV_ATTACK || env_kind_q == ENV_DECAY
					|| env_kind_q == ENV_RELEASE) begin
					div_ctrl.start = 1'b1;
					state_d = ST_DIV_WAIT;
				end else begin
					state_d = ST_AMP1;
				end
			end
			ST_DIV_WAIT: begin
				if (div_stat.done) begin
					state_d = ST_AMP1;
				end
			end
			ST_AMP1: begin
				mul_a = MUL_A_W'(osc_mag);
				mul_b = MUL_B_W'(env_q);
				state_d = ST_AMP2;
			end
			ST_AMP2: begin
				mul_a = MUL_A_W'(amp_mag);
				mul_b = MUL_B_W'(gain_q[v_q]);
				state_d = ST_FILT;
			end
			ST_FILT: begin
				state_d = (alpha_q < Q16_ONE) ? ST_FILT_MUL : ST_ACC;
			end
			ST_FILT_MUL: begin
				mul_a = MUL_A_W'(dry_q) - MUL_A_W'(cur_filter);
				mul_b = MUL_B_W'(alpha_q);
				state_d = ST_FILT_WR;
			end
			ST_FILT_WR: begin
				state_d = ST_ACC;
			end
			ST_ACC: begin
				advance = 1'b1;
				state_d = last_voice ? ST_MIX : ST_VSEL;
			end
			ST_MIX: begin
				mul_a = MUL_A_W'(acc_q);
				mul_b = MUL_B_W'(master_q);
				state_d = ST_MIX2;
			end
			ST_MIX2: begin
				state_d = ST_MIX3;
			end
			ST_MIX3: begin
				mul_a = MUL_A_W'(FULL_SCALE);
				mul_b = m_q;
				state_d = ST_MIX4;
			end
			ST_MIX4: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || mix.ready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer state, voice pointer, pool occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			v_q <= '0;
			cnt_q <= '0;
			active_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				v_q <= '0;
				if (cmd.operation == OP_PANIC) begin
					active_q <= '0;
					cnt_q <= '0;
				end
			end else if (note_wr) begin
				active_q[free_idx] <= 1'b1;
				cnt_q <= cnt_q + 1'b1;
			end else if (advance) begin
				if (expire) begin
					active_q[v_q] <= 1'b0;
					cnt_q <= cnt_q - 1'b1;
				end
				v_q <= v_q + 1'b1;
			end else if (state_q == ST_VSEL && !active_q[v_q]) begin
				v_q <= v_q + 1'b1;
			end
		end
	end

	// Configuration writes; the filter coefficient saturates at bypass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q <= WAVE_SINE;
			attack_q <= 20'd441;
			decay_q <= 20'd5292;
			sustain_q <= 16'd49152;
			release_q <= 20'd10584;
			alpha_q <= Q16_ONE;
			synth_vol_q <= 16'd52429;
			master_q <= 16'd52429;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_WAVE: wave_q <= cfg_data[1:0];
				CFG_ATTACK: attack_q <= cfg_data;
				CFG_DECAY: decay_q <= cfg_data;
				CFG_SUSTAIN: sustain_q <= cfg_data[15:0];
				CFG_RELEASE: release_q <= cfg_data;
				CFG_LOWPASS: alpha_q <= (cfg_data[16:0] > Q16_ONE) ? Q16_ONE : cfg_data[16:0];
				CFG_SYNTH_VOL: synth_vol_q <= cfg_data[15:0];
				CFG_MASTER_VOL: master_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Voice stores and per-voice datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			step_in_q <= cmd.phase_step;
			len_q <= cmd.note_length;
			vel_q <= cmd.note_velocity;
			acc_q <= '0;
			res_sample_q <= '0;
			res_status_q <= (cmd.operation == OP_PANIC) ? STAT_SILENCED : STAT_SAMPLE;
		end
		if (state_q == ST_NOTE_WR) begin
			res_status_q <= found ? STAT_ACCEPTED : STAT_DROPPED;
		end
		if (note_wr) begin
			phase_q[free_idx] <= '0;
			step_q[free_idx] <= step_in_q;
			elapsed_q[free_idx] <= '0;
			hold_q[free_idx] <= (len_q < 24'(MIN_TAIL)) ? 24'(MIN_TAIL) : len_q;
			gain_q[free_idx] <= mul_p[31:16];
			filter_q[free_idx] <= '0;
		end
		case (state_q)
			ST_VSEL: begin
				sine_q <= SINE_ROM[sine_idx];
				quad_q <= sine_k[SINE_W-1 -: 2];
				env_kind_q <= kind_d;
				env_x_q <= x_d;
			end
			ST_OSC: osc_q <= osc_d;
			ST_ENV_DIV: begin
				if (env_kind_q == ENV_SUSTAIN) begin
					env_q <= {1'b0, sustain_q};
				end else begin
					env_q <= '0;
				end
			end
			ST_DIV_WAIT: begin
				if (div_stat.done) begin
					env_q <= (env_kind_q == ENV_DECAY) ? Q16_ONE - div_q : div_q;
				end
			end
			ST_FILT: begin
				dry_q <= dry_d;
				wet_q <= dry_d;
			end
			ST_FILT_WR: begin
				filter_q[v_q] <= 18'(cur_filter + 18'(mix_t));
				wet_q <= 18'(cur_filter + 18'(mix_t));
			end
			ST_ACC: begin
				acc_q <= acc_q + ACC_W'(wet_q);
				phase_q[v_q] <= cur_phase + step_q[v_q];
				elapsed_q[v_q] <= e_next;
			end
			ST_MIX2: begin
				if (mix_t > 28'sd65536) begin
					m_q <= 18'sd65536;
				end else if (mix_t < -28'sd65536) begin
					m_q <= -18'sd65536;
				end else begin
					m_q <= 18'(mix_t);
				end
			end
			ST_MIX4: res_sample_q <= 16'(mix_t);
			default: ;
		endcase
	end

	// Output register: holds the result until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (mix.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sample_q <= res_sample_q;
			out_status_q <= res_status_q;
			out_count_q <= 5'(cnt_q);
		end
	end

	assign cmd.ready = state_q == ST_IDLE;
	assign mix.valid = out_valid_q;
	assign mix.audio_sample = $signed(out_sample_q);
	assign mix.status = out_status_q;
	assign mix.active_voices = out_count_q;

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == COUNT_W'($countones(active_q)))
		else $error("active count out of step with voice flags");
	a_non_tick_silent: assert property (@(posedge clk) disable iff (!arst_n)
		mix.valid && mix.status != STAT_SAMPLE |-> mix.audio_sample == 16'sd0)
		else $error("non-tick result carries a sample");
	a_panic_empty: assert property (@(posedge clk) disable iff (!arst_n)
		mix.valid && mix.status == STAT_SILENCED |-> mix.active_voices == 5'd0)
		else $error("voices left after panic");
endmodule

// ----- tb/sv/psm_checker.sv -----
// Result checker for the voice mixer: predicts every result and compares it.
`timescale 1ns / 1ps

module psm_checker (
	input logic clk,
	input logic arst_n,
	psm_cmd_if cmd,
	psm_mix_if mix,
	input logic cfg_write,
	input logic [2:0] cfg_index,
	input logic [19:0] cfg_data,
	output int errors,
	output int pending
);
	import psm_pkg::*;

	typedef struct packed {
		logic [15:0] sample;
		logic [1:0] status;
		logic [4:0] voices;
	} mix_result_t;

	// Predicted copy of the configuration registers.
	logic [1:0] shape;
	logic [19:0] attack_len;
	logic [19:0] decay_len;
	logic [15:0] sustain;
	logic [19:0] release_len;
	logic [16:0] alpha;
	logic [15:0] synth_vol;
	logic [15:0] master_vol;

	// Predicted copy of the voice pool.
	logic busy_voice [NUM_VOICES];
	logic [31:0] phase_acc [NUM_VOICES];
	logic [31:0] phase_inc [NUM_VOICES];
	logic [31:0] age [NUM_VOICES];
	logic [31:0] held [NUM_VOICES];
	logic [15:0] gain [NUM_VOICES];
	longint lp_state [NUM_VOICES];

	mix_result_t expected_mix [$];
	int mismatches;

	// Signed sine value from a Q30 series on the angle folded into the first quadrant.
	function automatic longint sine_value(longint unsigned k);
		longint unsigned num, quad, rem, x, x2, t, s, mag;
		num = 4 * k;
		quad = num / SINE_TABLE_DEPTH;
		rem = num % SINE_TABLE_DEPTH;
		if (quad[0]) begin
			rem = SINE_TABLE_DEPTH - rem;
		end
		x = rem * 64'd1686629713 / SINE_TABLE_DEPTH;
		x2 = (x * x) >> 30;
		t = 64'd1073741824 - x2 / 72;
		t = 64'd1073741824 - ((x2 * t) >> 30) / 42;
		t = 64'd1073741824 - ((x2 * t) >> 30) / 20;
		t = 64'd1073741824 - ((x2 * t) >> 30) / 6;
		s = (x * t) >> 30;
		mag = (s + 8192) >> 14;
		if (mag > 65536) begin
			mag = 65536;
		end
		return quad[1] ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic longint osc_value(logic [31:0] ph);
		longint u, d;
		u = longint'(ph[31:16]);
		case (shape)
			WAVE_SQUARE: return ph[31] ? -65536 : 65536;
			WAVE_TRIANGLE: begin
				d = u - 32768;
				if (d < 0) begin
					d = -d;
				end
				return 65536 - 4 * d;
			end
			WAVE_SAW: return 2 * u - 65536;
			default: return sine_value((longint'(ph) * SINE_TABLE_DEPTH) >> 32);
		endcase
	endfunction

	function automatic longint unsigned tail_len();
		return (release_len > MIN_TAIL) ? release_len : MIN_TAIL;
	endfunction

	// Linear ADSR level in Q16; release always falls from the sustain level.
	function automatic longint unsigned env_level(longint unsigned e, longint unsigned h);
		longint unsigned a, d, s, r;
		a = attack_len;
		d = decay_len;
		s = sustain;
		r = release_len;
		if (a > 0 && e < a) begin
			return e * 65536 / a;
		end
		if (d > 0 && e < a + d) begin
			return 65536 - ((65536 - s) * (e - a)) / d;
		end
		if (e < h) begin
			return s;
		end
		if (r > 0 && e < h + tail_len()) begin
			if (e - h >= r) begin
				return 0;
			end
			return s * (r - (e - h)) / r;
		end
		return 0;
	endfunction

	// Steps one voice and returns its filtered output.
	function automatic longint step_voice(int v);
		longint o, dry, wet;
		longint unsigned mag;
		o = osc_value(phase_acc[v]);
		mag = (o < 0) ? -o : o;
		mag = (mag * env_level(age[v], held[v])) >> 16;
		mag = (mag * gain[v]) >> 16;
		dry = (o < 0) ? -longint'(mag) : longint'(mag);
		if (alpha < 17'd65536) begin
			lp_state[v] = lp_state[v] + (longint'(alpha) * (dry - lp_state[v])) / 65536;
			wet = lp_state[v];
		end else begin
			wet = dry;
		end
		phase_acc[v] = phase_acc[v] + phase_inc[v];
		age[v] = age[v] + 1;
		if (longint'(age[v]) >= longint'(held[v]) + longint'(tail_len())) begin
			busy_voice[v] = 1'b0;
		end
		return wet;
	endfunction

	function automatic mix_result_t predict_mix(logic [1:0] op, logic [31:0] step,
			logic [23:0] len, logic [15:0] vel);
		mix_result_t r;
		longint sum;
		int n;
		r.sample = '0;
		if (op == OP_NOTE) begin
			r.status = STAT_DROPPED;
			for (int v = 0; v < NUM_VOICES; v++) begin
				if (!busy_voice[v]) begin
					busy_voice[v] = 1'b1;
					phase_acc[v] = '0;
					phase_inc[v] = step;
					age[v] = '0;
					held[v] = (len < MIN_TAIL) ? MIN_TAIL : len;
					gain[v] = 16'((32'(vel) * 32'(synth_vol)) >> 16);
					lp_state[v] = 0;
					r.status = STAT_ACCEPTED;
					break;
				end
			end
		end else if (op == OP_PANIC) begin
			for (int v = 0; v < NUM_VOICES; v++) begin
				busy_voice[v] = 1'b0;
			end
			r.status = STAT_SILENCED;
		end else begin
			sum = 0;
			for (int v = 0; v < NUM_VOICES; v++) begin
				if (busy_voice[v]) begin
					sum += step_voice(v);
				end
			end
			sum = (sum * longint'(master_vol)) / 65536;
			if (sum > 65536) begin
				sum = 65536;
			end
			if (sum < -65536) begin
				sum = -65536;
			end
			r.sample = 16'((sum * FULL_SCALE) / 65536);
			r.status = STAT_SAMPLE;
		end
		n = 0;
		for (int v = 0; v < NUM_VOICES; v++) begin
			n += busy_voice[v] ? 1 : 0;
		end
		r.voices = 5'(n);
		return r;
	endfunction

	// Follow the register writes and both channels at every clock edge.
	always @(posedge clk or negedge arst_n) begin
		mix_result_t got;
		mix_result_t want;
		if (!arst_n) begin
			shape = WAVE_SINE;
			attack_len = 20'd441;
			decay_len = 20'd5292;
			sustain = 16'd49152;
			release_len = 20'd10584;
			alpha = 17'd65536;
			synth_vol = 16'd52429;
			master_vol = 16'd52429;
			for (int v = 0; v < NUM_VOICES; v++) begin
				busy_voice[v] = 1'b0;
				phase_acc[v] = '0;
				age[v] = '0;
				lp_state[v] = 0;
			end
			expected_mix.delete();
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_WAVE: shape = cfg_data[1:0];
					CFG_ATTACK: attack_len = cfg_data;
					CFG_DECAY: decay_len = cfg_data;
					CFG_SUSTAIN: sustain = cfg_data[15:0];
					CFG_RELEASE: release_len = cfg_data;
					CFG_LOWPASS: alpha = (cfg_data[16:0] > 17'd65536) ? 17'd65536 :
						cfg_data[16:0];
					CFG_SYNTH_VOL: synth_vol = cfg_data[15:0];
					CFG_MASTER_VOL: master_vol = cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.valid && cmd.ready) begin
				expected_mix.insert(expected_mix.size(), predict_mix(cmd.operation,
					cmd.phase_step, cmd.note_length, cmd.note_velocity));
			end
			if (mix.valid && mix.ready) begin
				got.sample = mix.audio_sample;
				got.status = mix.status;
				got.voices = mix.active_voices;
				if (expected_mix.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: unexpected result sample %0d status %0d voices %0d",
							$realtime, $signed(got.sample), got.status, got.voices);
					end
				end else begin
					want = expected_mix.pop_front();
					if (got.sample !== want.sample || got.status !== want.status ||
							got.voices !== want.voices) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: mismatch expected %0d/%0d/%0d got %0d/%0d/%0d",
								$realtime, $signed(want.sample), want.status, want.voices,
								$signed(got.sample), got.status, got.voices);
						end
					end
				end
			end
		end
		pending = expected_mix.size();
	end

	assign errors = mismatches;

endmodule

// ----- tb/sv/tb.sv -----
// Stimulus and verdict for the voice mixer testbench.
`timescale 1ns / 1ps

module tb;
	import psm_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int STALL_LIMIT = 20000;
	localparam int PHASES = 7;
	localparam int ITEMS_PER_PHASE = 147;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [2:0] cfg_index;
	logic [19:0] cfg_data;
	logic calm;
	int errors;
	int pending;
	int quiet_cycles;

	psm_cmd_if cmd_ch();
	psm_mix_if mix_ch();

	polyphonic_adsr_synth_voice_mixer uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.mix(mix_ch),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	psm_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.mix(mix_ch),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sends one request, with a random gap unless traffic is running back to back.
	task automatic send_request(logic [1:0] op, logic [31:0] step, logic [23:0] len,
			logic [15:0] vel);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.operation <= op;
		cmd_ch.phase_step <= step;
		cmd_ch.note_length <= len;
		cmd_ch.note_velocity <= vel;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	// Drops valid and waits until every predicted result has come back.
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Writes all eight registers on consecutive cycles while the block is idle.
	task automatic load_settings(logic [19:0] vals [8]);
		for (int i = 0; i < 8; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_write <= 1'b0;
	endtask

	function automatic logic [23:0] pick_length();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) begin
			return 24'($urandom_range(0, 120));
		end
		if (r < 9) begin
			return 24'($urandom_range(0, 2000));
		end
		return 24'($urandom);
	endfunction

	// Result side: random ready stalls, none while traffic is calm.
	initial begin
		int gap;
		mix_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = calm ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				mix_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			mix_ch.ready <= 1'b1;
			do @(posedge clk); while (!mix_ch.valid);
		end
	end

	// Watchdog on cycles in which neither channel moves a request.
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (mix_ch.valid && mix_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL polyphonic_adsr_synth_voice_mixer");
			$finish;
		end
	end

	initial begin
		logic [19:0] vals [8];
		int r;
		calm = 1'b0;
		arst_n = 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= CFG_WAVE;
		cfg_data <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.operation <= OP_TICK;
		cmd_ch.phase_step <= '0;
		cmd_ch.note_length <= '0;
		cmd_ch.note_velocity <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on reset settings: empty ticks, the spare code, field
		// extremes, a full pool with one dropped note, then panic.
		send_request(OP_TICK, '0, '0, '0);
		send_request(OP_SPARE, '1, '1, '1);
		send_request(OP_NOTE, 32'd0, 24'd0, 16'd0);
		send_request(OP_NOTE, 32'hFFFF_FFFF, 24'hFF_FFFF, 16'hFFFF);
		for (int i = 0; i < 14; i++) begin
			send_request(OP_NOTE, $urandom, 24'($urandom_range(44, 60)), 16'($urandom));
		end
		send_request(OP_NOTE, $urandom, 24'd100, 16'hFFFF);
		send_request(OP_TICK, '0, '0, '0);
		send_request(OP_TICK, '0, '0, '0);
		send_request(OP_PANIC, '0, '0, '0);
		send_request(OP_TICK, '0, '0, '0);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			// Two phases at the register extremes, the rest random and mostly short.
			if (p == 0) begin
				vals = '{20'(WAVE_SQUARE), 20'd0, 20'd0, 20'hFFFF, 20'd0, 20'd0,
					20'hFFFF, 20'hFFFF};
			end else if (p == 1) begin
				vals = '{20'(WAVE_SINE), 20'hFFFFF, 20'hFFFFF, 20'd0, 20'hFFFFF,
					20'h1FFFF, 20'd0, 20'd0};
			end else begin
				vals[0] = 20'(p % 4);
				vals[1] = 20'($urandom_range(0, 60));
				vals[2] = 20'($urandom_range(0, 60));
				vals[3] = 20'($urandom_range(0, 65535));
				vals[4] = 20'($urandom_range(0, 100));
				vals[5] = (p == 3) ? 20'd65536 : 20'($urandom_range(0, 65536));
				vals[6] = 20'($urandom_range(0, 65535));
				vals[7] = 20'($urandom_range(0, 65535));
			end
			load_settings(vals);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (i % 40 == 0) begin
					calm = ($urandom_range(0, 2) == 0);
				end
				r = $urandom_range(0, 99);
				if (r < 55) begin
					send_request(OP_TICK, $urandom, 24'($urandom), 16'($urandom));
				end else if (r < 88) begin
					send_request(OP_NOTE, $urandom, pick_length(), 16'($urandom));
				end else if (r < 93) begin
					send_request(OP_SPARE, $urandom, 24'($urandom), 16'($urandom));
				end else begin
					send_request(OP_PANIC, $urandom, 24'($urandom), 16'($urandom));
				end
			end
			calm = 1'b0;
			drain();
		end

		repeat (50) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("PASS polyphonic_adsr_synth_voice_mixer");
		end else begin
			$display("FAIL polyphonic_adsr_synth_voice_mixer");
		end
		$finish;
	end

endmodule
